// ----- src/assert_macros.svh -----
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ----- src/cscf_pkg.sv -----
// Types and constants of the carrier-smoothed code filter.
package cscf_pkg;

    localparam int CHANNELS   = 64;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int MAX_COUNT  = 4095;
    localparam int CNT_W      = 13;
    localparam int DATA_W     = 48;
    localparam int WARM_W     = 4;
    localparam logic [WARM_W-1:0] WARM_RESET = 4'd5;

    // Widths of the intermediate values of the smoothing step.
    localparam int D_W    = DATA_W + 2;   // prev + lastphase - phase
    localparam int X_W    = DATA_W + 3;   // code - d
    localparam int NUM_W  = X_W;          // |code - d| + t/2
    localparam int SUM_W  = DATA_W + 4;   // d +/- quotient
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_DIFF  = 7'b0000100,
        S_ABS   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_CORR  = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] smoothed;
        logic signed [DATA_W-1:0] phase;
        logic [CNT_W-1:0]         count;
    } t_entry;

endpackage

// ----- src/cscf_in_if.sv -----
// Input channel: one epoch of one satellite channel per item.
interface cscf_in_if import cscf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          sat_id;
    logic signed [DATA_W-1:0] code_diff;
    logic signed [DATA_W-1:0] phase_diff;
    logic                     arc_start;
    logic                     in_arc;

    modport source (output valid, sat_id, code_diff, phase_diff, arc_start, in_arc,
                    input ready);
    modport sink   (input valid, sat_id, code_diff, phase_diff, arc_start, in_arc,
                    output ready);
endinterface

// ----- src/cscf_out_if.sv -----
// Output channel: one smoothed result per item.
interface cscf_out_if import cscf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          sat_echo;
    logic signed [DATA_W-1:0] smoothed_diff;
    logic                     settled;

    modport source (output valid, sat_echo, smoothed_diff, settled, input ready);
    modport sink   (input valid, sat_echo, smoothed_diff, settled, output ready);
endinterface

// ----- src/cscf_div.sv -----
// Restoring divider, one quotient bit per cycle, for the epoch-weight division.
module cscf_div import cscf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic [NUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    w_trial;
    logic              w_qbit;
    logic [CNT_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_step <= STEP_W'(NUM_W - 1);
        end else if (r_busy) begin
            // The remainder stays below the divisor, so the low bits hold it.
            r_rem  <= w_qbit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_num  <= {r_num[NUM_W-2:0], w_qbit};
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ----- src/carrier_smoothed_code_filter.sv -----
// Per-satellite carrier-smoothed code filter (Hatch filter) over Q31.16 differences.
// A smoothing epoch runs through load, difference, absolute value, the bit-serial divider
// (51 steps), correction and write-back; an arc start, an epoch outside an arc or one on an
// empty channel goes from load to write-back. Items are taken only while the block is idle.
// A result waiting in the output register holds the next item in write-back.
// Synchronous active-low reset clears control, all channel valid bits and sets warmup to 5.
`include "assert_macros.svh"

module carrier_smoothed_code_filter import cscf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WARM_W-1:0] i_cfg_wdata,
    cscf_in_if.sink           i_in,
    cscf_out_if.source        o_out
);

    t_state r_state, n_state;

    logic [WARM_W-1:0]        r_warm;
    logic [CHANNELS-1:0]      r_valid;
    t_entry                   mem_q [CHANNELS];
    t_entry                   r_rd;
    logic                     r_rd_valid;

    logic [CH_W-1:0]          r_sat;
    logic signed [DATA_W-1:0] r_code;
    logic signed [DATA_W-1:0] r_phase;
    logic                     r_start;
    logic                     r_arc;

    logic [CNT_W-1:0]         r_cnt;
    logic signed [D_W-1:0]    r_d;
    logic signed [X_W-1:0]    r_x;
    logic                     r_neg;
    logic signed [DATA_W-1:0] r_sm;

    logic                     r_o_valid;
    logic [CH_W-1:0]          r_o_sat;
    logic signed [DATA_W-1:0] r_o_sm;
    logic                     r_o_settled;

    logic                     w_in_acc;
    logic                     w_mem_we;
    logic [CNT_W-1:0]         w_cnt_old;
    logic [CNT_W-1:0]         w_half;
    logic [NUM_W-1:0]         w_num;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quot;
    logic signed [SUM_W-1:0]  w_d_ext;
    logic signed [SUM_W-1:0]  w_q_ext;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [D_W-1:0]    w_d;
    logic signed [X_W-1:0]    w_x;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_mem_we    = (r_state == S_WRITE) && (!r_o_valid || o_out.ready);
    assign w_div_start = (r_state == S_ABS);
    assign w_cnt_old   = r_rd_valid ? r_rd.count : '0;
    assign w_half      = r_cnt >> 1;

    always_comb begin
        w_d = {{2{r_rd.smoothed[DATA_W-1]}}, r_rd.smoothed}
            + {{2{r_rd.phase[DATA_W-1]}}, r_rd.phase}
            - {{2{r_phase[DATA_W-1]}}, r_phase};
        w_x = {{3{r_code[DATA_W-1]}}, r_code} - {r_d[D_W-1], r_d};
        // |x| + t/2 without a separate negation step.
        if (r_x[X_W-1]) begin
            w_num = NUM_W'({{(NUM_W-CNT_W){1'b0}}, w_half}) - NUM_W'(r_x);
        end else begin
            w_num = NUM_W'(r_x) + NUM_W'({{(NUM_W-CNT_W){1'b0}}, w_half});
        end
        w_d_ext = {{(SUM_W-D_W){r_d[D_W-1]}}, r_d};
        w_q_ext = {{(SUM_W-NUM_W){1'b0}}, w_quot};
        w_sum   = r_neg ? (w_d_ext - w_q_ext) : (w_d_ext + w_q_ext);
    end

    cscf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_num),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_LOAD;
            S_LOAD: begin
                if (!r_arc || r_start || w_cnt_old == '0) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF:  n_state = S_ABS;
            S_ABS:   n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_CORR;
            S_CORR:  n_state = S_WRITE;
            S_WRITE: if (w_mem_we) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_warm    <= WARM_RESET;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_warm <= i_cfg_wdata;
            end
            if (w_mem_we) begin
                r_valid[r_sat] <= 1'b1;
                r_o_valid      <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Channel state memory: read at acceptance, written back at the end of the item.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_q[r_sat] <= '{smoothed: r_sm, phase: r_phase, count: r_cnt};
        end
        if (w_in_acc) begin
            r_rd <= mem_q[i_in.sat_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sat      <= i_in.sat_id;
            r_code     <= i_in.code_diff;
            r_phase    <= i_in.phase_diff;
            r_start    <= i_in.arc_start;
            r_arc      <= i_in.in_arc;
            r_rd_valid <= r_valid[i_in.sat_id];
        end
        case (r_state)
            S_LOAD: begin
                r_sm <= r_code;
                r_d  <= w_d;
                if (!r_arc) begin
                    r_cnt <= '0;
                end else if (r_start || w_cnt_old == '0) begin
                    r_cnt <= CNT_W'(1);
                end else if (w_cnt_old >= CNT_W'(MAX_COUNT)) begin
                    r_cnt <= CNT_W'(MAX_COUNT);
                end else begin
                    r_cnt <= w_cnt_old + 1'b1;
                end
            end
            S_DIFF: r_x <= w_x;
            S_ABS:  r_neg <= r_x[X_W-1];
            S_CORR: begin
                // Saturate the corrected value to the signed 48-bit range.
                if (!w_sum[SUM_W-1] && (|w_sum[SUM_W-2:DATA_W-1])) begin
                    r_sm <= {1'b0, {(DATA_W-1){1'b1}}};
                end else if (w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:DATA_W-1])) begin
                    r_sm <= {1'b1, {(DATA_W-1){1'b0}}};
                end else begin
                    r_sm <= w_sum[DATA_W-1:0];
                end
            end
            default: ;
        endcase
        if (w_mem_we) begin
            r_o_sat <= r_sat;
            if (!r_arc) begin
                r_o_sm      <= r_code;
                r_o_settled <= 1'b0;
            end else if (r_cnt <= {{(CNT_W-WARM_W){1'b0}}, r_warm}) begin
                r_o_sm      <= '0;
                r_o_settled <= 1'b0;
            end else begin
                r_o_sm      <= r_sm;
                r_o_settled <= 1'b1;
            end
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.sat_echo      = r_o_sat;
    assign o_out.smoothed_diff = r_o_sm;
    assign o_out.settled       = r_o_settled;

    `CSCF_ASSERT_NXT(a_accept_loads, i_clk, i_rst_n, w_in_acc, r_state == S_LOAD)
    `CSCF_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `CSCF_ASSERT_NXT(a_write_marks, i_clk, i_rst_n, w_mem_we, r_o_valid && r_valid[r_sat])

endmodule

// ----- tb/tb_carrier_smoothed_code_filter.sv -----
// Self-checking testbench of the per-satellite Hatch filter with its own smoothing predictor.
`timescale 1ns / 100ps

module tb_carrier_smoothed_code_filter;
    import cscf_pkg::*;

    localparam int     LONG_HOLD    = 3000;
    localparam int     DRAIN_CYCLES = 120;
    localparam int     CYCLE_LIMIT  = 8_000_000;
    localparam longint SMOOTH_MAX   = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint SMOOTH_MIN   = -SMOOTH_MAX - 1;
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [CH_W-1:0]          sat_id;
        logic signed [DATA_W-1:0] code_diff;
        logic signed [DATA_W-1:0] phase_diff;
        logic                     arc_start;
        logic                     in_arc;
    } t_epoch;

    typedef struct packed {
        logic [CH_W-1:0]          sat_echo;
        logic signed [DATA_W-1:0] smoothed_diff;
        logic                     settled;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WARM_W-1:0] i_cfg_wdata;

    cscf_in_if  in_ch ();
    cscf_out_if out_ch ();

    carrier_smoothed_code_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state, one entry per satellite channel.
    longint  last_smooth [CHANNELS];
    longint  last_phase  [CHANNELS];
    int      arc_len     [CHANNELS];
    int      warmup_cfg = WARM_RESET;

    t_epoch  epoch_backlog [$];
    t_result smoothed_due  [$];
    t_epoch  next_epoch;
    t_epoch  taken_epoch;
    t_result want;

    int          send_gap      = 0;
    int          stall_left    = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          mismatch_count = 0;
    int          cycle_count   = 0;
    bit          quiet         = 1'b0;
    int unsigned tracked [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result smooth_epoch(t_epoch e);
        t_result r;
        longint  d, x, q, sm, t;
        r.sat_echo      = e.sat_id;
        r.smoothed_diff = e.code_diff;
        r.settled       = 1'b0;
        // A 6-bit channel number always lies inside the channel range.
        if (!e.in_arc) begin
            arc_len[e.sat_id]     = 0;
            last_smooth[e.sat_id] = e.code_diff;
            last_phase[e.sat_id]  = e.phase_diff;
        end else begin
            if (e.arc_start || arc_len[e.sat_id] == 0) begin
                t  = 1;
                sm = e.code_diff;
            end else begin
                t = arc_len[e.sat_id] + 1;
                if (t > MAX_COUNT) t = MAX_COUNT;
                d  = last_smooth[e.sat_id] + last_phase[e.sat_id] - longint'(e.phase_diff);
                x  = longint'(e.code_diff) - d;
                // Round to nearest with ties away from zero.
                q  = ((x < 0 ? -x : x) + t / 2) / t;
                sm = d + (x < 0 ? -q : q);
                if (sm > SMOOTH_MAX) begin
                    sm = SMOOTH_MAX;
                end else if (sm < SMOOTH_MIN) begin
                    sm = SMOOTH_MIN;
                end
            end
            arc_len[e.sat_id]     = int'(t);
            last_smooth[e.sat_id] = sm;
            last_phase[e.sat_id]  = e.phase_diff;
            if (t > warmup_cfg) begin
                r.smoothed_diff = sm[DATA_W-1:0];
                r.settled       = 1'b1;
            end else begin
                r.smoothed_diff = '0;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic signed [DATA_W-1:0] random_metres();
        int unsigned r;
        r = $urandom_range(0, 31);
        if (r == 0) return Q_MAX;
        if (r == 1) return Q_MIN;
        if (r < 6) return DATA_W'({$urandom, $urandom});
        return DATA_W'(int'($urandom));
    endfunction

    // Mostly continuing arcs on a few channels, with restarts and out-of-arc epochs mixed in.
    function automatic t_epoch random_epoch();
        t_epoch e;
        if ($urandom_range(0, 99) < 90) begin
            e.sat_id = CH_W'(tracked[$urandom_range(0, 7)]);
        end else begin
            e.sat_id = CH_W'($urandom);
        end
        e.code_diff  = random_metres();
        e.phase_diff = random_metres();
        e.in_arc     = $urandom_range(0, 99) >= 3;
        e.arc_start  = $urandom_range(0, 99) < 3;
        return e;
    endfunction

    task automatic push_epoch(input int unsigned sat, input logic signed [DATA_W-1:0] code,
                              input logic signed [DATA_W-1:0] phase, input bit start,
                              input bit arc);
        t_epoch e;
        e.sat_id     = CH_W'(sat);
        e.code_diff  = code;
        e.phase_diff = phase;
        e.arc_start  = start;
        e.in_arc     = arc;
        epoch_backlog.push_back(e);
    endtask

    // Returns at a falling edge once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        @(negedge i_clk);
        while (epoch_backlog.size() != 0 || in_ch.valid || smoothed_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_warmup(input int unsigned v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= WARM_W'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        warmup_cfg  = v;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int unsigned warm, input int n, input bit no_idle,
                                input bit hold);
        wait_idle();
        set_warmup(warm);
        quiet = no_idle;
        for (int k = 0; k < 8; k++) tracked[k] = $urandom_range(0, CHANNELS - 1);
        for (int k = 0; k < n; k++) epoch_backlog.push_back(random_epoch());
        if (hold) hold_req++;
    endtask

    // Sender: offers items from the backlog and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                taken_epoch.sat_id     = in_ch.sat_id;
                taken_epoch.code_diff  = in_ch.code_diff;
                taken_epoch.phase_diff = in_ch.phase_diff;
                taken_epoch.arc_start  = in_ch.arc_start;
                taken_epoch.in_arc     = in_ch.in_arc;
                smoothed_due.push_back(smooth_epoch(taken_epoch));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (epoch_backlog.size() != 0) begin
                    next_epoch        = epoch_backlog.pop_front();
                    in_ch.sat_id     <= next_epoch.sat_id;
                    in_ch.code_diff  <= next_epoch.code_diff;
                    in_ch.phase_diff <= next_epoch.phase_diff;
                    in_ch.arc_start  <= next_epoch.arc_start;
                    in_ch.in_arc     <= next_epoch.in_arc;
                    in_ch.valid      <= 1'b1;
                    send_gap         <= quiet ? 0 : pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            stall_left   <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 15) begin
            stall_left   <= pick_gap();
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (smoothed_due.size() == 0) begin
                $error("unexpected result for sat %0d", out_ch.sat_echo);
                mismatch_count++;
            end else begin
                want = smoothed_due.pop_front();
                if (out_ch.sat_echo !== want.sat_echo) begin
                    $error("sat_echo: expected %0d, got %0d", want.sat_echo, out_ch.sat_echo);
                    mismatch_count++;
                end
                if (out_ch.smoothed_diff !== want.smoothed_diff) begin
                    $error("smoothed_diff: expected %0d, got %0d",
                           want.smoothed_diff, out_ch.smoothed_diff);
                    mismatch_count++;
                end
                if (out_ch.settled !== want.settled) begin
                    $error("settled: expected %0b, got %0b", want.settled, out_ch.settled);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL carrier_smoothed_code_filter");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            last_smooth[c] = 0;
            last_phase[c]  = 0;
            arc_len[c]     = 0;
        end
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.sat_id     = '0;
        in_ch.code_diff  = '0;
        in_ch.phase_diff = '0;
        in_ch.arc_start  = 1'b0;
        in_ch.in_arc     = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed epochs under the reset warmup of five.
        // Outside an arc the code passes through and a start flag is ignored.
        push_epoch(0, Q_MAX, Q_MIN, 1'b1, 1'b0);
        push_epoch(0, Q_MIN, Q_MAX, 1'b0, 1'b0);
        // Phase jumps that drive the smoothed value past both ends of the range.
        push_epoch(1, Q_MAX, Q_MAX, 1'b1, 1'b1);
        push_epoch(1, Q_MAX, Q_MIN, 1'b0, 1'b1);
        push_epoch(1, Q_MAX, Q_MIN, 1'b0, 1'b1);
        push_epoch(2, Q_MIN, Q_MIN, 1'b1, 1'b1);
        push_epoch(2, Q_MIN, Q_MAX, 1'b0, 1'b1);
        // An arc opened without its start flag, then half-way ties of both signs.
        push_epoch(3, 0, 0, 1'b0, 1'b1);
        push_epoch(3, 1, 0, 1'b0, 1'b1);
        push_epoch(4, 0, 0, 1'b1, 1'b1);
        push_epoch(4, -1, 0, 1'b0, 1'b1);
        // A plain arc that runs past the warmup, restarts, and closes.
        push_epoch(63, 48'sd6553600, 48'sd6550000, 1'b1, 1'b1);
        for (int k = 1; k <= 6; k++)
            push_epoch(63, 48'sd6553600 + k * 977, 48'sd6550000 - k * 1531, 1'b0, 1'b1);
        push_epoch(63, -48'sd3276800, 48'sd1234567, 1'b1, 1'b1);
        push_epoch(63, 48'sd42, 48'sd17, 1'b1, 1'b0);
        push_epoch(63, 48'sd99, -48'sd5, 1'b0, 1'b1);

        random_phase(0, 500, 1'b0, 1'b1);
        random_phase(15, 450, 1'b1, 1'b0);
        random_phase($urandom_range(2, 14), 500, 1'b0, 1'b1);
        random_phase(5, 500, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && smoothed_due.size() == 0) begin
            $display("PASS carrier_smoothed_code_filter");
        end else begin
            $display("FAIL carrier_smoothed_code_filter");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/cscf_pkg.sv
src/cscf_in_if.sv
src/cscf_out_if.sv
src/cscf_div.sv
src/carrier_smoothed_code_filter.sv
tb/tb_carrier_smoothed_code_filter.sv
